### rtl/cpsp_pkg.sv
// ----------------------------------------------------------------------------
// cpsp_pkg
// Types and constants shared by the cascaded position/speed PID unit.
// ----------------------------------------------------------------------------
package cpsp_pkg;

  localparam int unsigned ErrW     = 32;  // saturated loop error
  localparam int unsigned DiffW    = ErrW + 1;
  localparam int unsigned GainW    = 16;  // unsigned Q8.8 gain
  localparam int unsigned LimW     = 15;  // output clamp magnitude
  localparam int unsigned ValW     = 16;  // setpoint / drive value
  localparam int unsigned ProdW    = DiffW + GainW + 1;
  localparam int unsigned AccW     = ProdW + 2;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic signed [31:0] target_position;
    logic signed [31:0] measured_position;
    logic signed [15:0] measured_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] drive_value;
    logic signed [15:0] speed_setpoint;
  } out_item_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OUTER_KP        = 4'd0,
    REG_OUTER_KI        = 4'd1,
    REG_OUTER_KD        = 4'd2,
    REG_OUTER_OUT_LIMIT = 4'd3,
    REG_INNER_KP        = 4'd4,
    REG_INNER_KI        = 4'd5,
    REG_INNER_KD        = 4'd6,
    REG_INNER_OUT_LIMIT = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [GainW-1:0] kp;
    logic [GainW-1:0] ki;
    logic [GainW-1:0] kd;
    logic [LimW-1:0]  out_limit;
  } loop_cfg_t;

  typedef struct packed {
    loop_cfg_t outer;
    loop_cfg_t inner;
  } gains_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_UPD,
    ST_OUT,
    ST_ERR
  } ctrl_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ERR,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_UPD,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   inner;  // 1: speed loop, 0: position loop
  } dp_cmd_t;

endpackage

### rtl/cpsp_cfg.sv
// ----------------------------------------------------------------------------
// cpsp_cfg
// Configuration register file: loop gains and output clamp magnitudes.
// ----------------------------------------------------------------------------
module cpsp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [cpsp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cpsp_pkg::CfgDataW-1:0] cfg_data_i,
  output cpsp_pkg::gains_t              gains_o
);

  cpsp_pkg::gains_t gains_d, gains_q;

  always_comb begin
    gains_d = gains_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        cpsp_pkg::REG_OUTER_KP:        gains_d.outer.kp = cfg_data_i;
        cpsp_pkg::REG_OUTER_KI:        gains_d.outer.ki = cfg_data_i;
        cpsp_pkg::REG_OUTER_KD:        gains_d.outer.kd = cfg_data_i;
        cpsp_pkg::REG_OUTER_OUT_LIMIT:
          gains_d.outer.out_limit = cfg_data_i[cpsp_pkg::LimW-1:0];
        cpsp_pkg::REG_INNER_KP:        gains_d.inner.kp = cfg_data_i;
        cpsp_pkg::REG_INNER_KI:        gains_d.inner.ki = cfg_data_i;
        cpsp_pkg::REG_INNER_KD:        gains_d.inner.kd = cfg_data_i;
        cpsp_pkg::REG_INNER_OUT_LIMIT:
          gains_d.inner.out_limit = cfg_data_i[cpsp_pkg::LimW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '0;
    end else begin
      gains_q <= gains_d;
    end
  end

  assign gains_o = gains_q;

endmodule

### rtl/cpsp_ctrl.sv
// ----------------------------------------------------------------------------
// cpsp_ctrl
// Sequencer: steps the shared datapath through both loops and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module cpsp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cpsp_pkg::dp_cmd_t cmd_o
);

  cpsp_pkg::ctrl_state_e state_d, state_q;
  logic                  inner_d, inner_q;
  logic                  out_valid_d, out_valid_q;
  logic                  slot_free;
  logic                  deliver;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    inner_d   = inner_q;
    deliver   = 1'b0;
    cmd_o.op    = cpsp_pkg::OP_NONE;
    cmd_o.inner = inner_q;
    in_ready_o  = 1'b0;
    case (state_q)
      cpsp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op    = cpsp_pkg::OP_ERR;
          cmd_o.inner = 1'b0;
          inner_d     = 1'b0;
          state_d     = cpsp_pkg::ST_MUL_P;
        end
      end
      cpsp_pkg::ST_ERR: begin
        cmd_o.op = cpsp_pkg::OP_ERR;
        state_d  = cpsp_pkg::ST_MUL_P;
      end
      cpsp_pkg::ST_MUL_P: begin
        cmd_o.op = cpsp_pkg::OP_MUL_P;
        state_d  = cpsp_pkg::ST_MUL_I;
      end
      cpsp_pkg::ST_MUL_I: begin
        cmd_o.op = cpsp_pkg::OP_MUL_I;
        state_d  = cpsp_pkg::ST_MUL_D;
      end
      cpsp_pkg::ST_MUL_D: begin
        cmd_o.op = cpsp_pkg::OP_MUL_D;
        state_d  = cpsp_pkg::ST_UPD;
      end
      cpsp_pkg::ST_UPD: begin
        cmd_o.op = cpsp_pkg::OP_UPD;
        state_d  = cpsp_pkg::ST_OUT;
      end
      cpsp_pkg::ST_OUT: begin
        if (!inner_q) begin
          cmd_o.op = cpsp_pkg::OP_OUT;
          inner_d  = 1'b1;
          state_d  = cpsp_pkg::ST_ERR;
        end else if (slot_free) begin
          // hold here until the output register can take the item
          cmd_o.op = cpsp_pkg::OP_OUT;
          deliver  = 1'b1;
          state_d  = cpsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cpsp_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || deliver;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpsp_pkg::ST_IDLE;
      inner_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      inner_q     <= inner_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/cpsp_datapath.sv
// ----------------------------------------------------------------------------
// cpsp_datapath
// Shared PID datapath: one multiplier, integrator and clamps, loop state of
// both loops, and the output item register.
// ----------------------------------------------------------------------------
module cpsp_datapath #(
  parameter int unsigned OUTER_INT_LIMIT = 8000,
  parameter int unsigned INNER_INT_LIMIT = 10000,
  parameter int unsigned GAIN_FRAC_BITS  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpsp_pkg::dp_cmd_t   cmd_i,
  input  cpsp_pkg::in_item_t  in_i,
  input  cpsp_pkg::gains_t    gains_i,
  output cpsp_pkg::out_item_t out_o
);

  localparam int unsigned ErrW  = cpsp_pkg::ErrW;
  localparam int unsigned DiffW = cpsp_pkg::DiffW;
  localparam int unsigned ProdW = cpsp_pkg::ProdW;
  localparam int unsigned AccW  = cpsp_pkg::AccW;
  localparam int unsigned ValW  = cpsp_pkg::ValW;
  localparam int unsigned SumW  = ProdW + 1;

  localparam logic signed [AccW-1:0] OuterLim = AccW'(OUTER_INT_LIMIT);
  localparam logic signed [AccW-1:0] InnerLim = AccW'(INNER_INT_LIMIT);

  // loop state
  logic signed [ErrW-1:0]  integ_q [2];
  logic signed [ErrW-1:0]  last_q  [2];
  // working registers
  logic signed [ErrW-1:0]  err_q;
  logic signed [ValW-1:0]  speed_q;
  logic signed [ValW-1:0]  setpoint_q;
  logic signed [ProdW-1:0] mul_q;
  logic signed [ProdW-1:0] p_q;
  logic signed [AccW-1:0]  acc_q;
  cpsp_pkg::out_item_t     out_q;

  logic                      sel;
  cpsp_pkg::loop_cfg_t       lcfg;
  logic signed [DiffW-1:0]   raw_err;
  logic signed [ErrW-1:0]    sat_err;
  logic signed [DiffW-1:0]   mul_a;
  logic signed [cpsp_pkg::GainW:0] mul_b;
  logic signed [ProdW-1:0]   prod;
  logic signed [ProdW-1:0]   prod_sh;
  logic signed [AccW-1:0]    int_sum;
  logic signed [AccW-1:0]    int_lim;
  logic signed [ErrW-1:0]    int_new;
  logic signed [SumW-1:0]    out_sum;
  logic signed [SumW-1:0]    out_lim;
  logic signed [ValW-1:0]    out_val;

  assign sel  = cmd_i.inner;
  assign lcfg = sel ? gains_i.inner : gains_i.outer;

  // loop error, saturated to 32 bits
  always_comb begin
    if (sel) begin
      raw_err = DiffW'(setpoint_q) - DiffW'(speed_q);
    end else begin
      raw_err = DiffW'(in_i.target_position) - DiffW'(in_i.measured_position);
    end
    if (raw_err[DiffW-1] != raw_err[DiffW-2]) begin
      sat_err = raw_err[DiffW-1] ? {1'b1, {(ErrW-1){1'b0}}} : {1'b0, {(ErrW-1){1'b1}}};
    end else begin
      sat_err = raw_err[ErrW-1:0];
    end
  end

  // shared multiplier, floor scaling by arithmetic shift
  always_comb begin
    mul_a = DiffW'(err_q);
    mul_b = {1'b0, lcfg.kp};
    case (cmd_i.op)
      cpsp_pkg::OP_MUL_I: mul_b = {1'b0, lcfg.ki};
      cpsp_pkg::OP_MUL_D: begin
        mul_a = DiffW'(err_q) - DiffW'(last_q[sel]);
        mul_b = {1'b0, lcfg.kd};
      end
      default: ;
    endcase
    prod    = ProdW'(mul_a) * ProdW'(mul_b);
    prod_sh = prod >>> GAIN_FRAC_BITS;
  end

  // integrator update: previous sum plus I and D products, then clamp
  always_comb begin
    int_sum = acc_q + AccW'(mul_q);
    int_lim = sel ? InnerLim : OuterLim;
    if (int_sum > int_lim) begin
      int_new = int_lim[ErrW-1:0];
    end else if (int_sum < -int_lim) begin
      int_new = ErrW'(-int_lim);
    end else begin
      int_new = int_sum[ErrW-1:0];
    end
  end

  // output P + I, clamped
  always_comb begin
    out_sum = SumW'(p_q) + SumW'(integ_q[sel]);
    out_lim = SumW'({1'b0, lcfg.out_limit});
    if (out_sum > out_lim) begin
      out_val = out_lim[ValW-1:0];
    end else if (out_sum < -out_lim) begin
      out_val = ValW'(-out_lim);
    end else begin
      out_val = out_sum[ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q[0] <= '0;
      integ_q[1] <= '0;
      last_q[0]  <= '0;
      last_q[1]  <= '0;
    end else if (cmd_i.op == cpsp_pkg::OP_UPD) begin
      integ_q[sel] <= int_new;
      last_q[sel]  <= err_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      cpsp_pkg::OP_ERR: begin
        err_q <= sat_err;
        if (!sel) begin
          speed_q <= in_i.measured_speed;
        end
      end
      cpsp_pkg::OP_MUL_P: mul_q <= prod_sh;
      cpsp_pkg::OP_MUL_I: begin
        p_q   <= mul_q;
        mul_q <= prod_sh;
      end
      cpsp_pkg::OP_MUL_D: begin
        acc_q <= AccW'(integ_q[sel]) + AccW'(mul_q);
        mul_q <= prod_sh;
      end
      cpsp_pkg::OP_OUT: begin
        if (sel) begin
          out_q.drive_value    <= out_val;
          out_q.speed_setpoint <= setpoint_q;
        end else begin
          setpoint_q <= out_val;
        end
      end
      default: ;
    endcase
  end

  assign out_o = out_q;

endmodule

### rtl/cascaded_position_speed_pid_unit.sv
// ----------------------------------------------------------------------------
// cascaded_position_speed_pid_unit
// Cascaded position/speed PID controller, one control tick per item.
// ----------------------------------------------------------------------------
// Each input item is one control tick. The position loop runs first on
// target minus measured position and yields the speed setpoint; the speed
// loop then runs on setpoint minus measured speed and yields the drive
// value. Both values come out together as one result item. Gains are
// unsigned Q8.8, products round toward minus infinity, the derivative term
// accumulates into the integrator, and the loop output is P plus I clamped
// to the programmed limit (a limit of zero forces zero). A new item is
// accepted only after the previous result is loaded, which waits for a
// free output register: a single shared 33x17 multiplier is stepped
// through P, I and D of each loop by the sequencer, with a separate step
// for the error, the integrator update and the output clamp; the position
// error is captured at the accepting edge itself. The next item is accepted
// in the cycle after a result is loaded, even while that result still
// waits for the consumer. Write the configuration registers only while no
// tick is in flight.
// ----------------------------------------------------------------------------
module cascaded_position_speed_pid_unit #(
  parameter int unsigned OUTER_INT_LIMIT = 8000,
  parameter int unsigned INNER_INT_LIMIT = 10000,
  parameter int unsigned GAIN_FRAC_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cpsp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cpsp_pkg::CfgDataW-1:0] cfg_data_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cpsp_pkg::in_item_t            in_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cpsp_pkg::out_item_t           out_o
);

  cpsp_pkg::gains_t  gains;
  cpsp_pkg::dp_cmd_t cmd;

  // register writes are always accepted; the register file never stalls
  assign cfg_ready_o = 1'b1;

  cpsp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .gains_o     (gains)
  );

  // sequencer: handshakes and per-cycle datapath commands
  cpsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  cpsp_datapath #(
    .OUTER_INT_LIMIT (OUTER_INT_LIMIT),
    .INNER_INT_LIMIT (INNER_INT_LIMIT),
    .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .in_i    (in_i),
    .gains_i (gains),
    .out_o   (out_o)
  );

endmodule
